>>> design/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the scrolled tile layer: payload beats,
// configuration view, operation and register codes, memory geometry.
// ----------------------------------------------------------------------------
package stl_pkg;

  // layer geometry
  localparam int unsigned TILE_COUNT    = 1024;  // power of two, 256..1024
  localparam int unsigned SCREEN_WIDTH  = 256;
  localparam int unsigned SCREEN_HEIGHT = 256;

  // video ram: 1024 words of {attribute, code}
  localparam int unsigned MAP_BYTES = 2048;
  localparam int unsigned MAP_WORDS = 1024;
  localparam int unsigned MAP_AW    = $clog2(MAP_WORDS);

  // tile rom: three planes of 0x8000 bytes, one 24-bit word per plane offset
  localparam int unsigned ROM_BYTES  = 98304;
  localparam int unsigned ROM_WORDS  = 32768;
  localparam int unsigned ROM_AW     = $clog2(ROM_WORDS);
  localparam int unsigned PLANES     = 3;
  localparam int unsigned CODE_W     = 10;

  typedef enum logic [1:0] {
    OP_MAP_WR = 2'd0,
    OP_ROM_WR = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } stl_op_e;

  typedef enum logic [1:0] {
    REG_SCROLL_X = 2'd0,
    REG_SCROLL_Y = 2'd1,
    REG_OFFSET_X = 2'd2,
    REG_OFFSET_Y = 2'd3
  } stl_reg_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [16:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  screen_x;
    logic [7:0]  screen_y;
    logic        front_pass;
  } stl_in_t;

  typedef struct packed {
    logic [5:0] palette_index;
    logic       pixel_drawn;
  } stl_out_t;

  typedef struct packed {
    logic [15:0] scroll_x;
    logic [15:0] scroll_y;
    logic [8:0]  offset_x;
    logic [8:0]  offset_y;
  } stl_cfg_t;

endpackage

>>> design/scrolled_tile_layer_pixel.sv
// ----------------------------------------------------------------------------
// scrolled_tile_layer_pixel
// Scrolled 16x16 tile background layer, one pixel per render beat.
// ----------------------------------------------------------------------------
// Takes one beat per clock when not stalled and returns one result beat per
// render beat, in order (none for memory writes or the unused operation). Two
// dependent memory reads lie in series: the video RAM read for the map entry,
// then the tile ROM read at the address it selects; each read is registered,
// and a result register follows. Writes go straight into the memories when
// taken; a write behind a render never disturbs it because the render's ROM
// read happens no later than the write. Memories need no clearing pass, as
// the user must read an entry only after it has been written. Scroll and
// offset sit in an APB-style register file at byte addresses 0, 4, 8 and 12;
// the user must change them only while the layer is idle. Neither is enforced.
// ----------------------------------------------------------------------------
module scrolled_tile_layer_pixel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stl_pkg::stl_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stl_pkg::stl_out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  stl_pkg::stl_cfg_t cfg;

  stl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline handshake
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_move, s2_free, s1_move, s1_free;
  logic accept, render_acc, map_we, rom_we;

  assign out_free = !out_v_q || out_ready_i;
  assign s2_move  = s2_v_q && out_free;
  assign s2_free  = !s2_v_q || s2_move;
  assign s1_move  = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s1_move;

  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && s1_free;
  assign render_acc = accept && (in_data_i.operation == stl_pkg::OP_RENDER);
  assign map_we     = accept && (in_data_i.operation == stl_pkg::OP_MAP_WR)
                      && (in_data_i.mem_address < 17'(stl_pkg::MAP_BYTES));
  assign rom_we     = accept && (in_data_i.operation == stl_pkg::OP_ROM_WR)
                      && (in_data_i.mem_address < 17'(stl_pkg::ROM_BYTES));

  // stage 0: map position and map entry address
  logic [8:0] map_x, map_y;
  logic       off_screen;
  logic [stl_pkg::MAP_AW-1:0] map_rd_addr;

  assign map_x = 9'({1'b0, in_data_i.screen_x} + cfg.scroll_x[8:0] + cfg.offset_x);
  assign map_y = 9'({1'b0, in_data_i.screen_y} + cfg.scroll_y[8:0] + cfg.offset_y);
  assign off_screen = ({1'b0, in_data_i.screen_x} >= 9'(stl_pkg::SCREEN_WIDTH))
                   || ({1'b0, in_data_i.screen_y} >= 9'(stl_pkg::SCREEN_HEIGHT));
  // column-major map
  assign map_rd_addr = {map_x[8:4], map_y[8:4]};

  logic [1:0][7:0] map_rd;

  stl_map_ram u_map_ram (
    .clk_i     (clk_i),
    .we_i      (map_we),
    .wr_addr_i (in_data_i.mem_address[stl_pkg::MAP_AW-1:0]),
    .wr_lane_i (in_data_i.mem_address[stl_pkg::MAP_AW]),
    .wr_data_i (in_data_i.mem_data),
    .re_i      (render_acc),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd)
  );

  logic       s1_off_q, s1_front_q;
  logic [3:0] s1_px_q, s1_py_q;

  // stage 1: decode attribute, apply flips, tile rom address
  logic [7:0] attr;
  logic [stl_pkg::CODE_W-1:0] code;
  logic [3:0] px, py;
  logic [stl_pkg::ROM_AW-1:0] rom_rd_addr;

  assign attr = map_rd[1];
  // tile count is a power of two, so the modulo is a mask
  assign code = {attr[7:6], map_rd[0]} & stl_pkg::CODE_W'(stl_pkg::TILE_COUNT - 1);
  assign px   = attr[4] ? ~s1_px_q : s1_px_q;
  assign py   = attr[5] ? ~s1_py_q : s1_py_q;
  assign rom_rd_addr = {code, px[3], py};

  logic [stl_pkg::PLANES-1:0][7:0] rom_rd;

  stl_tile_rom u_tile_rom (
    .clk_i      (clk_i),
    .we_i       (rom_we),
    .wr_addr_i  (in_data_i.mem_address[stl_pkg::ROM_AW-1:0]),
    .wr_plane_i (in_data_i.mem_address[stl_pkg::ROM_AW+1:stl_pkg::ROM_AW]),
    .wr_data_i  (in_data_i.mem_data),
    .re_i       (s1_move),
    .rd_addr_i  (rom_rd_addr),
    .rd_data_o  (rom_rd)
  );

  logic       s2_off_q, s2_front_q, s2_group_q;
  logic [2:0] s2_colour_q, s2_bit_q;

  // stage 2: pen, priority, result
  logic [2:0] pen;
  logic       is_front;
  stl_pkg::stl_out_t result, out_q;

  always_comb begin
    for (int p = 0; p < stl_pkg::PLANES; p++) begin
      pen[p] = rom_rd[p][~s2_bit_q];  // msb is the leftmost pixel
    end
    is_front = s2_group_q && ((pen == 3'd3) || (pen == 3'd4));
    if (s2_off_q) begin
      result = '0;
    end else begin
      result.palette_index = {s2_colour_q, pen};
      result.pixel_drawn   = s2_front_q ? is_front : !is_front;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= render_acc;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_acc) begin
      s1_off_q   <= off_screen;
      s1_front_q <= in_data_i.front_pass;
      s1_px_q    <= map_x[3:0];
      s1_py_q    <= map_y[3:0];
    end
    if (s1_move) begin
      s2_off_q    <= s1_off_q;
      s2_front_q  <= s1_front_q;
      s2_group_q  <= attr[3];
      s2_colour_q <= attr[2:0];
      s2_bit_q    <= px[2:0];
    end
    if (s2_move) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> design/stl_regs.sv
// ----------------------------------------------------------------------------
// stl_regs
// APB-style register file holding scroll and offset of the layer.
// ----------------------------------------------------------------------------
module stl_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output stl_pkg::stl_cfg_t  cfg_o
);

  stl_pkg::stl_cfg_t cfg_q;
  logic              wr_en;
  stl_pkg::stl_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = stl_pkg::stl_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        stl_pkg::REG_SCROLL_X: cfg_q.scroll_x <= pwdata[15:0];
        stl_pkg::REG_SCROLL_Y: cfg_q.scroll_y <= pwdata[15:0];
        stl_pkg::REG_OFFSET_X: cfg_q.offset_x <= pwdata[8:0];
        stl_pkg::REG_OFFSET_Y: cfg_q.offset_y <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      stl_pkg::REG_SCROLL_X: prdata = {16'd0, cfg_q.scroll_x};
      stl_pkg::REG_SCROLL_Y: prdata = {16'd0, cfg_q.scroll_y};
      stl_pkg::REG_OFFSET_X: prdata = {23'd0, cfg_q.offset_x};
      stl_pkg::REG_OFFSET_Y: prdata = {23'd0, cfg_q.offset_y};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/stl_map_ram.sv
// ----------------------------------------------------------------------------
// stl_map_ram
// Video RAM, one word per map entry holding code byte and attribute byte.
// Byte-lane write, one registered read.
// ----------------------------------------------------------------------------
module stl_map_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [stl_pkg::MAP_AW-1:0] wr_addr_i,
  input  logic                      wr_lane_i,
  input  logic [7:0]                wr_data_i,
  input  logic                      re_i,
  input  logic [stl_pkg::MAP_AW-1:0] rd_addr_i,
  output logic [1:0][7:0]           rd_data_o
);

  // lane 0 code byte, lane 1 attribute byte
  logic [1:0][7:0] mem [stl_pkg::MAP_WORDS];
  logic [1:0][7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i][wr_lane_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> design/stl_tile_rom.sv
// ----------------------------------------------------------------------------
// stl_tile_rom
// Tile graphics store, three planes side by side in one word so that one
// read yields all pen bits of a pixel. Byte-lane write, one registered read.
// ----------------------------------------------------------------------------
module stl_tile_rom (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [stl_pkg::ROM_AW-1:0]             wr_addr_i,
  input  logic [1:0]                             wr_plane_i,
  input  logic [7:0]                             wr_data_i,
  input  logic                                   re_i,
  input  logic [stl_pkg::ROM_AW-1:0]             rd_addr_i,
  output logic [stl_pkg::PLANES-1:0][7:0]        rd_data_o
);

  logic [stl_pkg::PLANES-1:0][7:0] mem [stl_pkg::ROM_WORDS];
  logic [stl_pkg::PLANES-1:0][7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i][wr_plane_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> bench/tb_scrolled_tile_layer_pixel.sv
// ----------------------------------------------------------------------------
// tb_scrolled_tile_layer_pixel
// Self-checking bench for the scrolled tile background layer.
// ----------------------------------------------------------------------------
// A short table of hand-computed beats runs first: tile code and flip extremes,
// both priority passes, ignored writes and the unused operation. Six random
// phases follow, each under fresh scroll and offset settings (all zero, all
// ones, then random). In those phases video RAM and tile ROM bytes are filled
// on demand before a pixel reads them. Every phase result is compared with a
// local pixel predictor, and the register file is read back after each setup.
// ----------------------------------------------------------------------------
module tb_scrolled_tile_layer_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PLANE_STRIDE = stl_pkg::ROM_WORDS;
  localparam int unsigned PHASE_BEATS  = 225;

  typedef struct {
    stl_pkg::stl_in_t  beat;
    bit                typed;
    stl_pkg::stl_out_t want;
  } pix_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  stl_pkg::stl_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  stl_pkg::stl_out_t out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // layer state as the predictor sees it
  logic [7:0]        map_mem [stl_pkg::MAP_BYTES];
  bit                map_set [stl_pkg::MAP_BYTES];
  logic [7:0]        rom_mem [stl_pkg::ROM_BYTES];
  bit                rom_set [stl_pkg::ROM_BYTES];
  stl_pkg::stl_cfg_t cfg;

  stl_pkg::stl_out_t pixel_q [$];
  pix_row_t          directed_rows [$];
  int                errors = 0;
  int                useful_beats = 0;
  int                s_run = 0;
  bit                s_calm = 0;
  int                r_run = 0;
  bit                r_calm = 0;

  scrolled_tile_layer_pixel uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** scrolled_tile_layer_pixel: FAILED **");
    $finish;
  end

  // runs of busy waits and runs of no waiting at all follow in random order
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(20, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // map entry, row byte offset inside a plane and flipped column of a pixel
  function automatic void tile_pixel(input logic [7:0] sx, input logic [7:0] sy,
                                     output int unsigned entry, output int unsigned off,
                                     output logic [3:0] px);
    logic [8:0] mx;
    logic [8:0] my;
    logic [3:0] py;
    logic [7:0] attr;
    logic [9:0] code;
    mx = 9'(sx + cfg.scroll_x + cfg.offset_x);
    my = 9'(sy + cfg.scroll_y + cfg.offset_y);
    entry = {mx[8:4], my[8:4]};
    attr = map_mem[entry + stl_pkg::MAP_WORDS];
    code = 10'({attr[7:6], map_mem[entry]} % stl_pkg::TILE_COUNT);
    px = attr[4] ? ~mx[3:0] : mx[3:0];
    py = attr[5] ? ~my[3:0] : my[3:0];
    off = code * 32 + py + (px[3] ? 16 : 0);
  endfunction

  function automatic bit predict_pixel(input stl_pkg::stl_in_t b,
                                       output stl_pkg::stl_out_t r);
    int unsigned entry;
    int unsigned off;
    logic [3:0]  px;
    logic [2:0]  pen;
    logic [7:0]  attr;
    bit          is_front;
    r = '0;
    case (b.operation)
      stl_pkg::OP_MAP_WR: begin
        if (b.mem_address < stl_pkg::MAP_BYTES) begin
          map_mem[b.mem_address] = b.mem_data;
          map_set[b.mem_address] = 1'b1;
        end
        return 1'b0;
      end
      stl_pkg::OP_ROM_WR: begin
        if (b.mem_address < stl_pkg::ROM_BYTES) begin
          rom_mem[b.mem_address] = b.mem_data;
          rom_set[b.mem_address] = 1'b1;
        end
        return 1'b0;
      end
      stl_pkg::OP_RENDER: begin
        if (b.screen_x >= stl_pkg::SCREEN_WIDTH || b.screen_y >= stl_pkg::SCREEN_HEIGHT) begin
          return 1'b1;
        end
        tile_pixel(b.screen_x, b.screen_y, entry, off, px);
        attr = map_mem[entry + stl_pkg::MAP_WORDS];
        for (int p = 0; p < stl_pkg::PLANES; p++) begin
          pen[p] = rom_mem[p * PLANE_STRIDE + off][7 - px[2:0]];
        end
        is_front = attr[3] && (pen == 3'd3 || pen == 3'd4);
        r.palette_index = {attr[2:0], pen};
        r.pixel_drawn = b.front_pass ? is_front : !is_front;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stl_pkg::stl_in_t noise_beat(input stl_pkg::stl_op_e op);
    stl_pkg::stl_in_t b;
    b.operation = op;
    b.mem_address = 17'($urandom_range(0, 17'h1FFFF));
    b.mem_data = 8'($urandom_range(0, 255));
    b.screen_x = 8'($urandom_range(0, 255));
    b.screen_y = 8'($urandom_range(0, 255));
    b.front_pass = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic void add_row(input stl_pkg::stl_op_e op, input int unsigned addr,
                                  input int unsigned data, input int unsigned sx,
                                  input int unsigned sy, input bit fr, input bit typed,
                                  input int unsigned idx, input bit drawn);
    pix_row_t row;
    row.beat.operation = op;
    row.beat.mem_address = 17'(addr);
    row.beat.mem_data = 8'(data);
    row.beat.screen_x = 8'(sx);
    row.beat.screen_y = 8'(sy);
    row.beat.front_pass = fr;
    row.typed = typed;
    row.want.palette_index = 6'(idx);
    row.want.pixel_drawn = drawn;
    directed_rows.push_back(row);
  endfunction

  task automatic send_beat(input stl_pkg::stl_in_t b, input bit typed,
                           input stl_pkg::stl_out_t want);
    int                gap;
    bit                has;
    stl_pkg::stl_out_t pix;
    gap = draw_wait(s_run, s_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    has = predict_pixel(b, pix);
    if (has) pixel_q.push_back(typed ? want : pix);
    if (b.operation == stl_pkg::OP_RENDER ||
        (b.operation == stl_pkg::OP_MAP_WR && b.mem_address < stl_pkg::MAP_BYTES) ||
        (b.operation == stl_pkg::OP_ROM_WR && b.mem_address < stl_pkg::ROM_BYTES)) begin
      useful_beats++;
    end
  endtask

  task automatic send_write(input stl_pkg::stl_op_e op, input int unsigned addr);
    stl_pkg::stl_in_t b;
    b = noise_beat(op);
    b.mem_address = 17'(addr);
    send_beat(b, 1'b0, '0);
  endtask

  // fill whatever the pixel is about to read, then render it
  task automatic render_pixel(input logic [7:0] sx, input logic [7:0] sy, input bit fr);
    int unsigned      entry;
    int unsigned      off;
    logic [3:0]       px;
    stl_pkg::stl_in_t b;
    tile_pixel(sx, sy, entry, off, px);
    if (!map_set[entry]) send_write(stl_pkg::OP_MAP_WR, entry);
    if (!map_set[entry + stl_pkg::MAP_WORDS]) begin
      send_write(stl_pkg::OP_MAP_WR, entry + stl_pkg::MAP_WORDS);
    end
    tile_pixel(sx, sy, entry, off, px);
    for (int p = 0; p < stl_pkg::PLANES; p++) begin
      if (!rom_set[p * PLANE_STRIDE + off]) begin
        send_write(stl_pkg::OP_ROM_WR, p * PLANE_STRIDE + off);
      end
    end
    b = noise_beat(stl_pkg::OP_RENDER);
    b.screen_x = sx;
    b.screen_y = sy;
    b.front_pass = fr;
    send_beat(b, 1'b0, '0);
  endtask

  // hold the sender off until every pixel is back and the pipe has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input stl_pkg::stl_reg_e r,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write all four registers with junk in the unused bits, then read back
  task automatic program_layer(input int ph);
    logic [31:0]        wdata;
    logic [31:0]        rdata;
    logic [31:0]        want;
    stl_pkg::stl_reg_e  r;
    for (int i = 0; i < 4; i++) begin
      r = stl_pkg::stl_reg_e'(i);
      wdata = $urandom;
      wdata[15:0] = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF :
                    16'($urandom_range(0, 65535));
      apb_access(1'b1, r, wdata, rdata);
      case (r)
        stl_pkg::REG_SCROLL_X: cfg.scroll_x = wdata[15:0];
        stl_pkg::REG_SCROLL_Y: cfg.scroll_y = wdata[15:0];
        stl_pkg::REG_OFFSET_X: cfg.offset_x = wdata[8:0];
        default:               cfg.offset_y = wdata[8:0];
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      r = stl_pkg::stl_reg_e'(i);
      apb_access(1'b0, r, '0, rdata);
      case (r)
        stl_pkg::REG_SCROLL_X: want = 32'(cfg.scroll_x);
        stl_pkg::REG_SCROLL_Y: want = 32'(cfg.scroll_y);
        stl_pkg::REG_OFFSET_X: want = 32'(cfg.offset_x);
        default:               want = 32'(cfg.offset_y);
      endcase
      if (rdata !== want) begin
        $display("%0t: register %s readback expected %h, got %h", $time, r.name(), want, rdata);
        errors++;
      end
    end
  endtask

  // result side: random stalls, every beat checked against the oldest prediction
  initial begin : pixel_sink
    int                stall;
    stl_pkg::stl_out_t want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(r_run, r_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel beat, got index %0d drawn %0d", $time,
                 out_data_o.palette_index, out_data_o.pixel_drawn);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (out_data_o.palette_index !== want.palette_index) begin
          $display("%0t: palette_index expected %0d, got %0d", $time,
                   want.palette_index, out_data_o.palette_index);
          errors++;
        end
        if (out_data_o.pixel_drawn !== want.pixel_drawn) begin
          $display("%0t: pixel_drawn expected %0d, got %0d", $time,
                   want.pixel_drawn, out_data_o.pixel_drawn);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int               pick;
    int               goal;
    int               n;
    logic [7:0]       bx;
    logic [7:0]       by;
    stl_pkg::stl_in_t b;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg = '0;

    // tile 0x3ff, both flips, group 1, colour 7: pixel (0,0) reads byte 31 of
    // the tile at bit 0 in each plane
    add_row(stl_pkg::OP_MAP_WR, 0, 'hFF, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_MAP_WR, 1024, 'hFF, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 32767, 'h01, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 65535, 'h01, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 98303, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_RENDER, 0, 0, 0, 0, 1, 1, 59, 1);
    add_row(stl_pkg::OP_RENDER, 0, 0, 0, 0, 0, 1, 59, 0);
    // writes past the end of either memory and the unused operation change nothing
    add_row(stl_pkg::OP_ROM_WR, 98304, 'hFF, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 131071, 'hFF, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_MAP_WR, 2048, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_MAP_WR, 131071, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 32767, 'hFE, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_RENDER, 0, 0, 0, 0, 1, 1, 58, 0);
    add_row(stl_pkg::OP_RENDER, 0, 0, 0, 0, 0, 1, 58, 1);
    // corner pixel (255,255): tile 0 unflipped, group 0, pen 5 stays in back
    add_row(stl_pkg::OP_MAP_WR, 495, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_MAP_WR, 1519, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 31, 'h01, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 32799, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 65567, 'h01, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_RENDER, 0, 0, 255, 255, 0, 1, 5, 1);
    add_row(stl_pkg::OP_RENDER, 0, 0, 255, 255, 1, 1, 5, 0);
    // group 1 with pen 4 moves to the front pass
    add_row(stl_pkg::OP_MAP_WR, 1519, 'h08, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_ROM_WR, 31, 'h00, 0, 0, 0, 0, 0, 0);
    add_row(stl_pkg::OP_RENDER, 0, 0, 255, 255, 1, 1, 4, 1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      program_layer(ph);
      goal = useful_beats + PHASE_BEATS;
      while (useful_beats < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // a run of pixels around one spot, mostly inside one tile
          bx = 8'($urandom_range(0, 255));
          by = 8'($urandom_range(0, 255));
          n = $urandom_range(1, 8);
          repeat (n) begin
            render_pixel(8'(bx + $urandom_range(0, 15)), 8'(by + $urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
          end
        end else if (pick < 70) begin
          render_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        end else if (pick < 82) begin
          send_write(stl_pkg::OP_MAP_WR, $urandom_range(0, stl_pkg::MAP_BYTES - 1));
        end else if (pick < 94) begin
          send_write(stl_pkg::OP_ROM_WR, $urandom_range(0, stl_pkg::ROM_BYTES - 1));
        end else if (pick < 97) begin
          send_write(stl_pkg::OP_ROM_WR, $urandom_range(stl_pkg::ROM_BYTES, 17'h1FFFF));
        end else if (pick < 99) begin
          send_write(stl_pkg::OP_MAP_WR, $urandom_range(stl_pkg::MAP_BYTES, 17'h1FFFF));
        end else begin
          b = noise_beat(stl_pkg::OP_NONE);
          send_beat(b, 1'b0, '0);
        end
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("** scrolled_tile_layer_pixel: PASSED **");
    end else begin
      $display("** scrolled_tile_layer_pixel: FAILED **");
    end
    $finish;
  end

endmodule
